>>> hdl/ledet_pkg.sv
// Shared constants, types and codes for the local extrema detector.
package ledet_pkg;

    localparam int MAX_RADIUS = 8;
    localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int IDX_W      = $clog2(WIN_DEPTH);
    localparam int CNT_W      = $clog2(WIN_DEPTH + 1);

    localparam int DATA_W = 32;
    localparam int MODE_W = 2;
    localparam int RAD_W  = 4;
    localparam int TOL_W  = 31;
    localparam int DIST_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_MIN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_BOTH;
    localparam logic [RAD_W-1:0]  RADIUS_RESET = 4'd3;

    typedef struct packed {
        logic shift;
        logic compare;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic                     has_point;
        logic                     stream_done;
        logic                     run_last;
    } result_t;

endpackage

>>> hdl/ledet_cell.sv
// One window cell: holds a point, passes it on, and checks it against the centre.
module ledet_cell (
    input  logic                                     clk,
    input  ledet_pkg::cell_ctrl_t                    ctrl,
    input  logic signed [ledet_pkg::DATA_W-1:0]      x_in,
    input  logic signed [ledet_pkg::DATA_W-1:0]      y_in,
    input  logic signed [ledet_pkg::DATA_W-1:0]      centre_y,
    input  logic        [ledet_pkg::TOL_W-1:0]       tolerance,
    output logic signed [ledet_pkg::DATA_W-1:0]      x,
    output logic signed [ledet_pkg::DATA_W-1:0]      y,
    output logic                                     lo_ok,
    output logic                                     hi_ok
);

    logic signed [ledet_pkg::DATA_W-1:0] x_reg;
    logic signed [ledet_pkg::DATA_W-1:0] y_reg;
    logic                                lo_ok_reg;
    logic                                hi_ok_reg;
    logic signed [ledet_pkg::DATA_W:0]   tol_ext;
    logic signed [ledet_pkg::DATA_W:0]   diff_down;
    logic signed [ledet_pkg::DATA_W:0]   diff_up;

    always_comb
    begin
        tol_ext   = $signed({{(ledet_pkg::DATA_W + 1 - ledet_pkg::TOL_W){1'b0}}, tolerance});
        diff_down = {centre_y[ledet_pkg::DATA_W-1], centre_y} - {y_reg[ledet_pkg::DATA_W-1], y_reg};
        diff_up   = {y_reg[ledet_pkg::DATA_W-1], y_reg} - {centre_y[ledet_pkg::DATA_W-1], centre_y};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
        end
        // a neighbor lower than the centre by more than the tolerance rules out a minimum
        if (ctrl.compare)
        begin
            lo_ok_reg <= !(diff_down > tol_ext);
            hi_ok_reg <= !(diff_up > tol_ext);
        end
    end

    assign x     = x_reg;
    assign y     = y_reg;
    assign lo_ok = lo_ok_reg;
    assign hi_ok = hi_ok_reg;

endmodule

>>> hdl/local_extrema_detector_core.sv
// Top level: window cell chain, evaluation sequencer, pending merge and result queue.
// Steps: after a point is accepted the sequencer picks the centre, the cells compare, then the merge runs.
// A new point is taken only when the sequencer is idle again after the three steps;
// merge waits while the two-entry result queue still holds results.
// Reset (rst_n low, asynchronous) empties the stream state and the queue and loads
// register defaults: both modes, radius 3, tolerance 0, merge distance 0.
module local_extrema_detector_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ledet_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ledet_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [ledet_pkg::DATA_W-1:0]   sample_x,
    input  logic signed [ledet_pkg::DATA_W-1:0]   sample_y,
    input  logic                                  last_sample,
    output logic                                  point_valid,
    input  logic                                  point_stall,
    output logic signed [ledet_pkg::DATA_W-1:0]   point_x,
    output logic signed [ledet_pkg::DATA_W-1:0]   point_y,
    output logic                                  has_point,
    output logic                                  stream_done,
    output logic                                  run_last
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CENTER = 4'b0010,
        S_CMP    = 4'b0100,
        S_MERGE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [ledet_pkg::MODE_W-1:0] mode_reg;
    logic [ledet_pkg::RAD_W-1:0]  radius_reg;
    logic [ledet_pkg::TOL_W-1:0]  tol_reg;
    logic [ledet_pkg::DIST_W-1:0] dist_reg;

    logic [ledet_pkg::CNT_W-1:0]  seen_reg;
    logic [ledet_pkg::CNT_W-1:0]  seen_next;
    logic                         last_reg;
    logic                         pend_valid_reg;
    logic                         pend_valid_next;
    logic signed [ledet_pkg::DATA_W-1:0] pend_x_reg;
    logic signed [ledet_pkg::DATA_W-1:0] pend_x_next;
    logic signed [ledet_pkg::DATA_W-1:0] pend_y_reg;
    logic signed [ledet_pkg::DATA_W-1:0] pend_y_next;
    logic signed [ledet_pkg::DATA_W-1:0] cx_reg;
    logic signed [ledet_pkg::DATA_W-1:0] cy_reg;

    ledet_pkg::result_t q_reg [2];
    ledet_pkg::result_t q_next [2];
    logic [1:0]         q_cnt_reg;
    logic [1:0]         q_cnt_next;

    logic signed [ledet_pkg::DATA_W-1:0] cell_x [ledet_pkg::WIN_DEPTH];
    logic signed [ledet_pkg::DATA_W-1:0] cell_y [ledet_pkg::WIN_DEPTH];
    logic [ledet_pkg::WIN_DEPTH-1:0]     cell_lo_ok;
    logic [ledet_pkg::WIN_DEPTH-1:0]     cell_hi_ok;
    logic [ledet_pkg::WIN_DEPTH-1:0]     cell_mask;
    ledet_pkg::cell_ctrl_t               cell_ctrl;

    logic                         in_accept;
    logic                         out_pop;
    logic                         merge_go;
    logic [ledet_pkg::IDX_W-1:0]  r_eff;
    logic [ledet_pkg::IDX_W-1:0]  span;
    logic                         win_full;
    logic                         is_min;
    logic                         is_max;
    logic                         report;
    logic signed [ledet_pkg::DATA_W:0] dx;
    logic [ledet_pkg::DATA_W:0]   dx_abs;
    logic                         near;
    logic                         replace;
    logic                         emit_a;
    ledet_pkg::result_t           res_a;
    ledet_pkg::result_t           res_b;

    assign in_accept    = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);
    assign out_pop      = point_valid && !point_stall;
    assign merge_go     = (state_reg == S_MERGE) && (q_cnt_reg == 2'd0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ledet_pkg::MODE_RESET;
            radius_reg <= ledet_pkg::RADIUS_RESET;
            tol_reg    <= '0;
            dist_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ledet_pkg::REG_MODE:   mode_reg   <= cfg_data[ledet_pkg::MODE_W-1:0];
                ledet_pkg::REG_RADIUS: radius_reg <= cfg_data[ledet_pkg::RAD_W-1:0];
                ledet_pkg::REG_TOL:    tol_reg    <= cfg_data[ledet_pkg::TOL_W-1:0];
                ledet_pkg::REG_MERGE:  dist_reg   <= cfg_data[ledet_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp radius into 1..MAX_RADIUS
    always_comb
    begin
        if (32'(radius_reg) > 32'(ledet_pkg::MAX_RADIUS))
            r_eff = ledet_pkg::IDX_W'(ledet_pkg::MAX_RADIUS);
        else if (radius_reg == '0)
            r_eff = ledet_pkg::IDX_W'(1);
        else
            r_eff = ledet_pkg::IDX_W'(radius_reg);
        span     = ledet_pkg::IDX_W'({r_eff, 1'b0});
        win_full = seen_reg >= (ledet_pkg::CNT_W'(span) + ledet_pkg::CNT_W'(1));
    end

    // cell chain
    assign cell_ctrl.shift   = in_accept;
    assign cell_ctrl.compare = (state_reg == S_CMP);

    for (genvar i = 0; i < ledet_pkg::WIN_DEPTH; i++)
    begin : g_cell
        logic signed [ledet_pkg::DATA_W-1:0] x_in;
        logic signed [ledet_pkg::DATA_W-1:0] y_in;

        if (i == 0)
        begin : g_head
            assign x_in = sample_x;
            assign y_in = sample_y;
        end
        else
        begin : g_link
            assign x_in = cell_x[i-1];
            assign y_in = cell_y[i-1];
        end

        ledet_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .x_in      (x_in),
            .y_in      (y_in),
            .centre_y  (cy_reg),
            .tolerance (tol_reg),
            .x         (cell_x[i]),
            .y         (cell_y[i]),
            .lo_ok     (cell_lo_ok[i]),
            .hi_ok     (cell_hi_ok[i])
        );

        assign cell_mask[i] = (ledet_pkg::IDX_W'(i) <= span) && (ledet_pkg::IDX_W'(i) != r_eff);
    end

    // decide, merge and assemble results
    always_comb
    begin
        is_min  = &(cell_lo_ok | ~cell_mask);
        is_max  = &(cell_hi_ok | ~cell_mask);
        report  = win_full &&
                  (((mode_reg == ledet_pkg::MODE_MIN) && is_min) ||
                   ((mode_reg == ledet_pkg::MODE_MAX) && is_max) ||
                   ((mode_reg == ledet_pkg::MODE_BOTH) && (is_min || is_max)));
        dx      = {pend_x_reg[ledet_pkg::DATA_W-1], pend_x_reg} -
                  {cx_reg[ledet_pkg::DATA_W-1], cx_reg};
        dx_abs  = dx[ledet_pkg::DATA_W] ? (ledet_pkg::DATA_W+1)'(-dx) : dx;
        near    = pend_valid_reg && (dx_abs <= {1'b0, dist_reg});
        replace = (is_max && (cy_reg > pend_y_reg)) || (is_min && (cy_reg < pend_y_reg)) ||
                  (mode_reg == ledet_pkg::MODE_BOTH);
        emit_a  = report && !near && pend_valid_reg;

        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        if (report && (!near || replace))
        begin
            pend_valid_next = 1'b1;
            pend_x_next     = cx_reg;
            pend_y_next     = cy_reg;
        end

        res_a.x           = pend_x_reg;
        res_a.y           = pend_y_reg;
        res_a.has_point   = 1'b1;
        res_a.stream_done = 1'b0;
        res_a.run_last    = !last_reg;

        // final result: flush pending point or send empty end marker
        res_b.x           = pend_valid_next ? pend_x_next : '0;
        res_b.y           = pend_valid_next ? pend_y_next : '0;
        res_b.has_point   = pend_valid_next;
        res_b.stream_done = 1'b1;
        res_b.run_last    = 1'b1;
    end

    // result queue
    always_comb
    begin
        q_next     = q_reg;
        q_cnt_next = q_cnt_reg;
        if (merge_go)
        begin
            if (emit_a)
            begin
                q_next[0]  = res_a;
                q_next[1]  = res_b;
                q_cnt_next = last_reg ? 2'd2 : 2'd1;
            end
            else
            begin
                q_next[0]  = res_b;
                q_cnt_next = last_reg ? 2'd1 : 2'd0;
            end
        end
        else if (out_pop)
        begin
            q_next[0]  = q_reg[1];
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign point_valid = (q_cnt_reg != 2'd0);
    assign point_x     = q_reg[0].x;
    assign point_y     = q_reg[0].y;
    assign has_point   = q_reg[0].has_point;
    assign stream_done = q_reg[0].stream_done;
    assign run_last    = q_reg[0].run_last;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_accept) state_next = S_CENTER;
            S_CENTER: state_next = S_CMP;
            S_CMP:    state_next = S_MERGE;
            S_MERGE:  if (merge_go) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (in_accept && (seen_reg < ledet_pkg::CNT_W'(ledet_pkg::WIN_DEPTH)))
            seen_next = seen_reg + ledet_pkg::CNT_W'(1);
        else if (merge_go && last_reg)
            seen_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seen_reg       <= '0;
            last_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            q_cnt_reg      <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            q_cnt_reg <= q_cnt_next;
            if (in_accept)
                last_reg <= last_sample;
            // drop the stream state after the last point
            if (merge_go)
                pend_valid_reg <= pend_valid_next && !last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CENTER)
        begin
            cx_reg <= cell_x[r_eff];
            cy_reg <= cell_y[r_eff];
        end
        if (merge_go)
        begin
            pend_x_reg <= pend_x_next;
            pend_y_reg <= pend_y_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state not one-hot");

    assert property (@(posedge clk) disable iff (!rst_n) q_cnt_reg != 2'd3)
        else $error("result queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (merge_go && last_reg) |=> (!pend_valid_reg && (seen_reg == '0)))
        else $error("stream state not cleared after last point");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_cnt_reg == 2'd2) |-> (q_reg[1].run_last && !q_reg[0].run_last))
        else $error("run_last misplaced in queued results");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> sample_stall)
        else $error("request taken while busy");

endmodule

>>> bench/tb.sv
// Testbench for local_extrema_detector_core: directed and random point streams with prediction.
`timescale 1ns / 1ps

module tb;

    localparam logic [ledet_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 40;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [ledet_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [ledet_pkg::DATA_W-1:0]        cfg_data = '0;
    logic                                sample_valid = 1'b0;
    logic                                sample_stall;
    logic signed [ledet_pkg::DATA_W-1:0] sample_x = '0;
    logic signed [ledet_pkg::DATA_W-1:0] sample_y = '0;
    logic                                last_sample = 1'b0;
    logic                                point_valid;
    logic                                point_stall = 1'b0;
    logic signed [ledet_pkg::DATA_W-1:0] point_x;
    logic signed [ledet_pkg::DATA_W-1:0] point_y;
    logic                                has_point;
    logic                                stream_done;
    logic                                run_last;

    // register copies and stream state of the predictor
    logic [ledet_pkg::MODE_W-1:0] mode_q = ledet_pkg::MODE_RESET;
    logic [ledet_pkg::RAD_W-1:0]  radius_q = ledet_pkg::RADIUS_RESET;
    logic [ledet_pkg::TOL_W-1:0]  tol_q = '0;
    logic [ledet_pkg::DIST_W-1:0] merge_q = '0;
    longint            win_x [ledet_pkg::WIN_DEPTH];
    longint            win_y [ledet_pkg::WIN_DEPTH];
    int                held_count;
    bit                pend_valid;
    longint            pend_x;
    longint            pend_y;

    ledet_pkg::result_t expected_points [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      stall_left = 0;
    bit      idle_enable = 1'b1;
    bit      sender_gaps = 1'b1;

    local_extrema_detector_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .last_sample  (last_sample),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .has_point    (has_point),
        .stream_done  (stream_done),
        .run_last     (run_last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_points.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void clear_window();
        for (int i = 0; i < ledet_pkg::WIN_DEPTH; i++)
        begin
            win_x[i] = 0;
            win_y[i] = 0;
        end
        held_count = 0;
        pend_valid = 1'b0;
        pend_x = 0;
        pend_y = 0;
    endfunction

    function automatic ledet_pkg::result_t pack_point(longint x, longint y, logic has,
                                                      logic done);
        ledet_pkg::result_t p;
        p.x = x[ledet_pkg::DATA_W-1:0];
        p.y = y[ledet_pkg::DATA_W-1:0];
        p.has_point = has;
        p.stream_done = done;
        p.run_last = 1'b0;
        return p;
    endfunction

    // Shift one point into the window, test the centre and queue the points it releases.
    function automatic void detect_extrema(logic signed [ledet_pkg::DATA_W-1:0] x,
                                           logic signed [ledet_pkg::DATA_W-1:0] y,
                                           logic last);
        ledet_pkg::result_t found [$];
        int      r;
        longint  cx;
        longint  cy;
        longint  tol;
        longint  x_gap;
        bit      is_min;
        bit      is_max;
        bit      report;
        r = int'(radius_q);
        if (r < 1)
            r = 1;
        if (r > ledet_pkg::MAX_RADIUS)
            r = ledet_pkg::MAX_RADIUS;
        for (int i = ledet_pkg::WIN_DEPTH - 1; i > 0; i--)
        begin
            win_x[i] = win_x[i-1];
            win_y[i] = win_y[i-1];
        end
        win_x[0] = longint'(x);
        win_y[0] = longint'(y);
        if (held_count < ledet_pkg::WIN_DEPTH)
            held_count++;

        if (held_count >= 2 * r + 1)
        begin
            cx = win_x[r];
            cy = win_y[r];
            tol = longint'(tol_q);
            is_min = 1'b1;
            is_max = 1'b1;
            for (int i = 0; i <= 2 * r; i++)
            begin
                if (i != r)
                begin
                    if (cy > win_y[i] + tol)
                        is_min = 1'b0;
                    if (cy < win_y[i] - tol)
                        is_max = 1'b0;
                end
            end
            case (mode_q)
                ledet_pkg::MODE_MIN:  report = is_min;
                ledet_pkg::MODE_MAX:  report = is_max;
                ledet_pkg::MODE_BOTH: report = is_min || is_max;
                default:              report = 1'b0;
            endcase
            if (report)
            begin
                x_gap = pend_x - cx;
                if (x_gap < 0)
                    x_gap = -x_gap;
                if (pend_valid && x_gap <= longint'(merge_q))
                begin
                    if ((is_max && cy > pend_y) || (is_min && cy < pend_y) ||
                        mode_q == ledet_pkg::MODE_BOTH)
                    begin
                        pend_x = cx;
                        pend_y = cy;
                    end
                end
                else
                begin
                    if (pend_valid)
                        found = {found, pack_point(pend_x, pend_y, 1'b1, 1'b0)};
                    pend_valid = 1'b1;
                    pend_x = cx;
                    pend_y = cy;
                end
            end
        end

        if (last)
        begin
            if (pend_valid)
                found = {found, pack_point(pend_x, pend_y, 1'b1, 1'b1)};
            else
                found = {found, pack_point(0, 0, 1'b0, 1'b1)};
            clear_window();
        end

        if (found.size() > 0)
            found[found.size()-1].run_last = 1'b1;
        foreach (found[i])
            expected_points = {expected_points, found[i]};
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [ledet_pkg::DATA_W-1:0] got,
                               input logic [ledet_pkg::DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // result side: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            point_stall <= 1'b1;
        end
        else if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            point_stall <= 1'b1;
        end
        else
            point_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_points
        ledet_pkg::result_t want;
        if (rst_n && point_valid && !point_stall)
        begin
            if (expected_points.size() == 0)
                report_mismatch($sformatf("unexpected point x=%h y=%h done=%b",
                                          point_x, point_y, stream_done));
            else
            begin
                want = expected_points.pop_front();
                check_field("point_x", point_x, want.x);
                check_field("point_y", point_y, want.y);
                check_field("has_point", has_point, want.has_point);
                check_field("stream_done", stream_done, want.stream_done);
                check_field("run_last", run_last, want.run_last);
            end
        end
    end

    // Present one request and hold it until accepted.
    task automatic send_point(input logic signed [ledet_pkg::DATA_W-1:0] x,
                              input logic signed [ledet_pkg::DATA_W-1:0] y, input logic last);
        if (idle_enable && sender_gaps && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_x <= x;
        sample_y <= y;
        last_sample <= last;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        detect_extrema(x, y, last);
    endtask

    // Drop valid, drain every expected result, then let the pipeline empty.
    task automatic settle();
        sample_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ledet_pkg::CFG_IDX_W-1:0] index,
                             input logic [ledet_pkg::DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        case (index)
            ledet_pkg::REG_MODE:   mode_q = value[ledet_pkg::MODE_W-1:0];
            ledet_pkg::REG_RADIUS: radius_q = value[ledet_pkg::RAD_W-1:0];
            ledet_pkg::REG_TOL:    tol_q = value[ledet_pkg::TOL_W-1:0];
            ledet_pkg::REG_MERGE:  merge_q = value[ledet_pkg::DIST_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic set_config(input logic [ledet_pkg::DATA_W-1:0] mode_v,
                              input logic [ledet_pkg::DATA_W-1:0] radius_v,
                              input logic [ledet_pkg::DATA_W-1:0] tol_v,
                              input logic [ledet_pkg::DATA_W-1:0] merge_v);
        settle();
        write_reg(ledet_pkg::REG_MODE, mode_v);
        write_reg(ledet_pkg::REG_RADIUS, radius_v);
        write_reg(ledet_pkg::REG_TOL, tol_v);
        write_reg(ledet_pkg::REG_MERGE, merge_v);
        cfg_we <= 1'b0;
    endtask

    // Stream shorter than the reset window: only the end marker comes out.
    task automatic test_short_stream();
        send_point(0, 5, 1'b0);
        send_point(1, 1, 1'b0);
        send_point(2, 7, 1'b0);
        send_point(3, 2, 1'b1);
    endtask

    // Full-scale y swings with the largest tolerance; bit 31 of the tolerance write is dropped.
    task automatic test_wide_compare();
        set_config(ledet_pkg::MODE_BOTH, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 32'h8000_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    endtask

    // Minima only, maxima only and the unused mode, all with a radius of zero.
    task automatic test_modes();
        logic [ledet_pkg::MODE_W-1:0] modes [3];
        modes[0] = ledet_pkg::MODE_MIN;
        modes[1] = ledet_pkg::MODE_MAX;
        modes[2] = MODE_UNUSED;
        foreach (modes[m])
        begin
            set_config(modes[m], 0, 0, 0);
            for (int i = 0; i < 5; i++)
                send_point(10 * i, (i % 2 == 0) ? 3 : -3, i == 4);
        end
    endtask

    // Hold the stream mid-way until all results are out, shrink the radius, merge close points.
    task automatic test_merge_and_resize();
        int ys [8];
        ys = '{0, 4, 1, 5, 2, 6, 1, 3};
        set_config(ledet_pkg::MODE_BOTH, 3, 0, 2);
        for (int i = 0; i < 5; i++)
            send_point(i, ys[i], 1'b0);
        settle();
        write_reg(ledet_pkg::REG_RADIUS, 1);
        cfg_we <= 1'b0;
        for (int i = 5; i < 8; i++)
            send_point(i, ys[i], i == 7);
    endtask

    task automatic send_random_stream(input int len);
        logic signed [ledet_pkg::DATA_W-1:0] x;
        logic signed [ledet_pkg::DATA_W-1:0] y;
        int x_style;
        int y_style;
        bit ends;
        x_style = $urandom_range(0, 3);
        y_style = $urandom_range(0, 2);
        ends = $urandom_range(0, 7) != 0;
        sender_gaps = $urandom_range(0, 3) != 0;
        x = $urandom;
        y = $urandom;
        for (int i = 0; i < len; i++)
        begin
            if (x_style == 0)
                x = $urandom;
            else
                x = x + $urandom_range(0, 20);
            case (y_style)
                0: y = $urandom;
                1: y = int'($urandom_range(0, 7)) - 4;
                default: y = y + int'($urandom_range(0, 200)) - 100;
            endcase
            send_point(x, y, ends && i == len - 1);
        end
        sender_gaps = 1'b1;
    endtask

    function automatic logic [ledet_pkg::DATA_W-1:0] pick_tolerance();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $urandom_range(0, 3);
            2: return $urandom_range(0, 300);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ledet_pkg::DATA_W-1:0] pick_merge();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $urandom_range(0, 40);
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Eight settings of at least 50 points each; the last one runs without idling.
    task automatic test_random_streams();
        int sent;
        int len;
        int radius_v;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    radius_v = 15;
                    set_config(ledet_pkg::MODE_BOTH, 15, 0, 0);
                end
                1:
                begin
                    radius_v = 8;
                    set_config(ledet_pkg::MODE_MIN, 8, 2, 10);
                end
                2:
                begin
                    radius_v = 1;
                    set_config(ledet_pkg::MODE_MAX, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                end
                3:
                begin
                    radius_v = 2;
                    set_config(MODE_UNUSED, 2, 0, 0);
                end
                default:
                begin
                    radius_v = $urandom_range(0, 15);
                    set_config($urandom_range(0, 2), radius_v, pick_tolerance(), pick_merge());
                end
            endcase
            idle_enable = (phase != 7);
            sent = 0;
            while (sent < 50)
            begin
                if (radius_v > 4)
                    len = $urandom_range(10, 40);
                else
                    len = $urandom_range(1, 24);
                send_random_stream(len);
                sent += len;
            end
        end
    endtask

    initial
    begin
        clear_window();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_short_stream();
        test_wide_compare();
        test_modes();
        test_merge_and_resize();
        test_random_streams();
        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ledet_pkg.sv
hdl/ledet_cell.sv
hdl/local_extrema_detector_core.sv
bench/tb.sv
